>>> design/dfs_path_finder_defines.svh
// Assertion macros used by the path finder checker.
`ifndef DFS_PATH_FINDER_DEFINES_SVH
`define DFS_PATH_FINDER_DEFINES_SVH

// Check on every edge outside reset.
`define DFS_ASSERT_RST(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error(msg);

// Check on every edge, reset included.
`define DFS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

>>> design/dfs_pkg.sv
// Shared types and constants of the depth-first path finder.
package dfs_pkg;

  localparam int VERTEX_W         = 6;
  localparam int CMD_W            = 2;
  localparam int VCOUNT_W         = 7;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int PADDR_W          = 3;
  localparam int PDATA_W          = 32;
  localparam int REG_IDX_W        = PADDR_W - 2;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_EDGE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = 1'b0;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [VERTEX_W-1:0] from_vertex;
    logic [VERTEX_W-1:0] to_vertex;
  } in_item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] path_vertex;
    logic                found;
    logic                last;
  } out_item_t;

endpackage

>>> design/dfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/dfs_front.sv
// Front end: accepts items, drops those with no effect, queues the rest.
module dfs_front import dfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  input  logic     q_ready,
  output in_item_t q_item
);

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = QAW + 1;
  localparam logic [VCOUNT_W-1:0] MAXV = VCOUNT_W'(MAX_VERTICES);

  in_item_t         entries_r [QUEUE_DEPTH];
  logic [QAW-1:0]   wptr_r, wptr_nxt;
  logic [QAW-1:0]   rptr_r, rptr_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  logic             keep;
  logic             push;
  logic             pop;
  logic             edge_ok;

  assign edge_ok = ({1'b0, in_data.from_vertex} < MAXV) &&
                   ({1'b0, in_data.to_vertex} < MAXV);

  always_comb begin
    case (in_data.cmd)
      CMD_CLEAR:  keep = 1'b1;
      CMD_SEARCH: keep = 1'b1;
      CMD_EDGE:   keep = edge_ok;
      default:    keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != QCW'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_item   = entries_r[rptr_r];
  assign push     = in_valid && in_ready && keep;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wptr_nxt = push ? wptr_r + QAW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + QAW'(1) : rptr_r;
    cnt_nxt  = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wptr_r] <= in_data;
    end
  end

endmodule

>>> design/dfs_engine.sv
// Back end: adjacency matrix, search stack, search sequencer and result register.
module dfs_engine import dfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [VCOUNT_W-1:0] vertex_count,
  input  logic                q_valid,
  output logic                q_ready,
  input  in_item_t            q_item,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int DW = VW + 1;
  localparam logic [VCOUNT_W-1:0] MAXV = VCOUNT_W'(MAX_VERTICES);
  localparam logic [MAX_VERTICES-1:0] ONE_V = MAX_VERTICES'(1);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EDGE_WR = 3'd1;
  localparam logic [2:0] ST_EVAL    = 3'd2;
  localparam logic [2:0] ST_POP     = 3'd3;
  localparam logic [2:0] ST_EMIT_RD = 3'd4;
  localparam logic [2:0] ST_EMIT_WR = 3'd5;
  localparam logic [2:0] ST_MISS    = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic [VW-1:0]           a_r, a_nxt;
  logic [VW-1:0]           b_r, b_nxt;
  logic [DW-1:0]           depth_r, depth_nxt;
  logic [VW-1:0]           k_r, k_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] mask_r, mask_nxt;
  logic [MAX_VERTICES-1:0] row_vld_r, row_vld_nxt;
  logic                    vldq_r, vldq_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic                    adj_we, adj_re;
  logic [VW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    stk_we, stk_re;
  logic [VW-1:0]           stk_waddr, stk_raddr;
  logic [VW-1:0]           stk_wdata, stk_rdata;

  logic [VCOUNT_W-1:0]     live_cnt;
  logic [MAX_VERTICES-1:0] live_mask;
  logic [MAX_VERTICES-1:0] cand;
  logic [VW-1:0]           next_v;
  logic [DW-1:0]           pop_idx;
  logic                    slot_free;
  logic                    emit_last;
  logic                    start_ok;
  logic                    tgt_ok;

  dfs_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .re    (adj_re),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  dfs_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign live_cnt = (vertex_count > MAXV) ? MAXV : vertex_count;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      live_mask[i] = (VCOUNT_W'(i) < live_cnt);
    end
  end

  assign start_ok = ({1'b0, q_item.from_vertex} < live_cnt);
  assign tgt_ok   = ({1'b0, q_item.to_vertex} < live_cnt);

  assign cand = (vldq_r ? adj_rdata : '0) & ~visited_r & mask_r;

  always_comb begin
    next_v = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_v = VW'(i);
      end
    end
  end

  assign pop_idx   = depth_r - DW'(2);
  assign slot_free = !out_valid_r || out_ready;
  assign emit_last = ((DW'(k_r) + DW'(1)) == depth_r);

  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    depth_nxt     = depth_r;
    k_nxt         = k_r;
    visited_nxt   = visited_r;
    mask_nxt      = mask_r;
    row_vld_nxt   = row_vld_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    q_ready       = 1'b0;
    adj_we        = 1'b0;
    adj_waddr     = a_r;
    adj_wdata     = (vldq_r ? adj_rdata : '0) | (ONE_V << b_r);
    adj_re        = 1'b0;
    adj_raddr     = a_r;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = a_r;
    stk_re        = 1'b0;
    stk_raddr     = k_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          a_nxt = q_item.from_vertex[VW-1:0];
          b_nxt = q_item.to_vertex[VW-1:0];
          case (q_item.cmd)
            CMD_CLEAR: begin
              row_vld_nxt = '0;
            end
            CMD_EDGE: begin
              adj_re    = 1'b1;
              adj_raddr = q_item.from_vertex[VW-1:0];
              state_nxt = ST_EDGE_WR;
            end
            CMD_SEARCH: begin
              mask_nxt = live_mask;
              if (!start_ok || !tgt_ok) begin
                state_nxt = ST_MISS;
              end else begin
                stk_we      = 1'b1;
                stk_waddr   = '0;
                stk_wdata   = q_item.from_vertex[VW-1:0];
                depth_nxt   = DW'(1);
                k_nxt       = '0;
                visited_nxt = ONE_V << q_item.from_vertex[VW-1:0];
                if (q_item.from_vertex == q_item.to_vertex) begin
                  state_nxt = ST_EMIT_RD;
                end else begin
                  adj_re    = 1'b1;
                  adj_raddr = q_item.from_vertex[VW-1:0];
                  state_nxt = ST_EVAL;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_EDGE_WR: begin
        adj_we           = 1'b1;
        row_vld_nxt[a_r] = 1'b1;
        state_nxt        = ST_IDLE;
      end
      ST_EVAL: begin
        if (cand != '0) begin
          stk_we      = 1'b1;
          stk_waddr   = depth_r[VW-1:0];
          stk_wdata   = next_v;
          depth_nxt   = depth_r + DW'(1);
          visited_nxt = visited_r | (ONE_V << next_v);
          if (next_v == b_r) begin
            k_nxt     = '0;
            state_nxt = ST_EMIT_RD;
          end else begin
            adj_re    = 1'b1;
            adj_raddr = next_v;
          end
        end else if (depth_r == DW'(1)) begin
          state_nxt = ST_MISS;
        end else begin
          stk_re    = 1'b1;
          stk_raddr = pop_idx[VW-1:0];
          depth_nxt = depth_r - DW'(1);
          state_nxt = ST_POP;
        end
      end
      ST_POP: begin
        adj_re    = 1'b1;
        adj_raddr = stk_rdata;
        state_nxt = ST_EVAL;
      end
      ST_EMIT_RD: begin
        stk_re    = 1'b1;
        stk_raddr = k_r;
        state_nxt = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.path_vertex = VERTEX_W'(stk_rdata);
          out_data_nxt.found       = 1'b1;
          out_data_nxt.last        = emit_last;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + VW'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      ST_MISS: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.path_vertex = '0;
          out_data_nxt.found       = 1'b0;
          out_data_nxt.last        = 1'b1;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign vldq_nxt = adj_re ? row_vld_r[adj_raddr] : vldq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    depth_r    <= depth_nxt;
    k_r        <= k_nxt;
    visited_r  <= visited_nxt;
    mask_r     <= mask_nxt;
    vldq_r     <= vldq_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/dfs_path_finder.sv
// Top level of the depth-first path finder with its configuration register.
//
// Input channel in_*: one command per transfer (clear graph, add edge, search path).
// Result channel out_*: one transfer per path vertex, start first, last set on the
// final one; an unreachable target gives a single transfer with found low.
// Configuration: APB register vertex_count at byte address 0. The user must write it
// only while idle; the block itself does not enforce this. A two-entry command queue
// in the front end feeds the engine, so commands are taken while the engine works
// and while a result waits in the output register. Clear marks every matrix row
// empty; add edge is a read-modify-write of one matrix row. A search pushes the
// start vertex, then in each step pushes an unvisited neighbour or pops the stack,
// waiting on the registered reads of the matrix and stack RAMs; each path vertex
// is then read from the stack and delivered. A stalled receiver holds the result
// register, and the sequencer once it has a result to write; the queue keeps taking
// commands until it is full. Reset empties the graph, the queue and the output
// register and sets vertex_count to 64; no clearing pass is needed.
module dfs_path_finder import dfs_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [VCOUNT_W-1:0] vcount_r, vcount_nxt;
  logic                reg_hit;
  logic                q_valid;
  logic                q_ready;
  in_item_t            q_item;

  assign reg_hit = (paddr[PADDR_W-1:2] == REG_VERTEX_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? PDATA_W'(vcount_r) : '0;

  always_comb begin
    vcount_nxt = vcount_r;
    if (psel && penable && pwrite && pready && reg_hit) begin
      vcount_nxt = pwdata[VCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= VCOUNT_RESET;
    end else begin
      vcount_r <= vcount_nxt;
    end
  end

  dfs_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  dfs_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .vertex_count (vcount_r),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

>>> design/dfs_checker.sv
// Port-level checker for the path finder, bound to the top level.
`include "dfs_path_finder_defines.svh"

module dfs_checker import dfs_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `DFS_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")
  `DFS_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |=> !out_valid, "result valid right after reset")
  `DFS_ASSERT_RST(a_miss_last, clk, rst_n, out_valid && !out_data.found |-> out_data.last, "not-found result without last")
  `DFS_ASSERT_RST(a_miss_zero, clk, rst_n, out_valid && !out_data.found |-> out_data.path_vertex == '0, "not-found result with nonzero vertex")

endmodule

bind dfs_path_finder dfs_checker u_dfs_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for dfs_path_finder: graph commands and searches checked against a path predictor.
module tb;
  import dfs_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 4000;

  class path_scoreboard;
    bit [63:0]         adj_rows[64];
    bit [VCOUNT_W-1:0] vcount;
    out_item_t         path_q[$];
    int                errors;

    function new();
      vcount = VCOUNT_RESET;
      errors = 0;
      foreach (adj_rows[i]) adj_rows[i] = '0;
    endfunction

    function void set_vertex_count(bit [VCOUNT_W-1:0] v);
      vcount = v;
    endfunction

    function void push_hop(bit [VERTEX_W-1:0] v, bit f, bit l);
      out_item_t e;
      e.path_vertex = v;
      e.found = f;
      e.last = l;
      path_q = {path_q, e};
    endfunction

    function void find_path(bit [VERTEX_W-1:0] start, bit [VERTEX_W-1:0] target);
      int                cnt;
      bit [63:0]         live;
      bit [63:0]         seen;
      bit [63:0]         cand;
      bit [VERTEX_W-1:0] stack[64];
      bit [VERTEX_W-1:0] parent[64];
      bit [VERTEX_W-1:0] walk[64];
      bit [VERTEX_W-1:0] top;
      bit [VERTEX_W-1:0] cur;
      int                depth;
      int                len;
      int                nxt;
      cnt = (vcount > 64) ? 64 : int'(vcount);
      live = (cnt >= 64) ? '1 : ((64'd1 << cnt) - 64'd1);
      if (start >= cnt || target >= cnt) begin
        push_hop('0, 1'b0, 1'b1);
        return;
      end
      foreach (parent[i]) parent[i] = '0;
      stack[0] = start;
      depth = 1;
      seen = 64'd1 << start;
      while (depth > 0) begin
        top = stack[depth-1];
        cand = adj_rows[top] & ~seen & live;
        if (cand != 0 && depth < 64) begin
          nxt = 0;
          for (int b = 0; b < 64; b++) begin
            if (cand[b]) begin
              nxt = b;
              break;
            end
          end
          stack[depth] = VERTEX_W'(nxt);
          depth++;
          parent[nxt] = top;
          seen[nxt] = 1'b1;
        end else begin
          depth--;
        end
      end
      if (!seen[target]) begin
        push_hop('0, 1'b0, 1'b1);
        return;
      end
      cur = target;
      walk[0] = cur;
      len = 1;
      while (cur != start && len < cnt) begin
        cur = parent[cur];
        walk[len] = cur;
        len++;
      end
      for (int k = 0; k < len; k++) push_hop(walk[len-1-k], 1'b1, k == len - 1);
    endfunction

    function void note_command(in_item_t it);
      case (it.cmd)
        CMD_CLEAR: begin
          foreach (adj_rows[i]) adj_rows[i] = '0;
        end
        CMD_EDGE: begin
          adj_rows[it.from_vertex][it.to_vertex] = 1'b1;
        end
        CMD_SEARCH: begin
          find_path(it.from_vertex, it.to_vertex);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_hop(out_item_t got);
      out_item_t want;
      if (path_q.size() == 0) begin
        $error("unexpected transfer: path_vertex %0d found %0b last %0b",
               got.path_vertex, got.found, got.last);
        errors++;
        return;
      end
      want = path_q.pop_front();
      if (got.found !== want.found) begin
        $error("found mismatch: expected %0b, actual %0b", want.found, got.found);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last mismatch: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
      if (got.path_vertex !== want.path_vertex) begin
        $error("path_vertex mismatch: expected %0d, actual %0d",
               want.path_vertex, got.path_vertex);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  path_scoreboard sb = new();
  int             items_sent = 0;
  int             burst_left = 0;
  int             stall_cycles = 0;
  bit             hold_req = 1'b0;

  dfs_path_finder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_hop(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("dfs_path_finder test failed");
        $finish;
      end
    end
  end

  initial begin
    int rx_mode;
    int span;
    rx_mode = 0;
    span = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (span == 0) begin
          rx_mode = $urandom_range(0, 3);
          span = $urandom_range(16, 96);
        end
        span--;
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (span % 4 == 0);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [VERTEX_W-1:0] a,
                          logic [VERTEX_W-1:0] b);
    in_item_t it;
    int       gap;
    it.cmd = cmd;
    it.from_vertex = a;
    it.to_vertex = b;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_command(it);
    items_sent++;
  endtask

  task automatic wait_drained();
    while (sb.path_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(logic [VCOUNT_W-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    wait_drained();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_VERTEX_COUNT, 2'b00};
    pwdata <= PDATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_vertex_count(v);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [VERTEX_W-1:0] pick_vertex(int ce);
    if ($urandom_range(0, 19) == 0) return VERTEX_W'($urandom_range(0, 63));
    return VERTEX_W'($urandom_range(0, ce - 1));
  endfunction

  task automatic random_phase(int budget);
    int                ce;
    int                first;
    int                n;
    logic [VERTEX_W-1:0] head;
    logic [VERTEX_W-1:0] prev;
    logic [VERTEX_W-1:0] nxt;
    logic [VERTEX_W-1:0] src;
    logic [VERTEX_W-1:0] dst;
    ce = (sb.vcount > 64) ? 64 : int'(sb.vcount);
    if (ce == 0) ce = 1;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 2) == 0)
          send_cmd(CMD_CLEAR, VERTEX_W'($urandom), VERTEX_W'($urandom));
        head = pick_vertex(ce);
        prev = head;
        n = $urandom_range(1, (ce < 12) ? ce : 12);
        for (int i = 0; i < n; i++) begin
          nxt = pick_vertex(ce);
          send_cmd(CMD_EDGE, prev, nxt);
          prev = nxt;
        end
        n = $urandom_range(0, 8);
        for (int i = 0; i < n; i++) send_cmd(CMD_EDGE, pick_vertex(ce), pick_vertex(ce));
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          src = ($urandom_range(0, 2) != 0) ? head : pick_vertex(ce);
          dst = ($urandom_range(0, 1) != 0) ? prev : pick_vertex(ce);
          send_cmd(CMD_SEARCH, src, dst);
        end
      end else begin
        send_cmd(CMD_W'($urandom_range(0, 3)), VERTEX_W'($urandom_range(0, 63)),
                 VERTEX_W'($urandom_range(0, 63)));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_CLEAR, 6'd0, 6'd0);
    send_cmd(CMD_EDGE, 6'd0, 6'd1);
    send_cmd(CMD_EDGE, 6'd1, 6'd2);
    send_cmd(CMD_EDGE, 6'd0, 6'd63);
    send_cmd(CMD_EDGE, 6'd63, 6'd0);
    send_cmd(CMD_EDGE, 6'd2, 6'd1);
    send_cmd(CMD_SEARCH, 6'd0, 6'd2);
    send_cmd(CMD_SEARCH, 6'd0, 6'd63);
    send_cmd(CMD_SEARCH, 6'd5, 6'd5);
    send_cmd(CMD_SEARCH, 6'd1, 6'd0);
    send_cmd(CMD_SPARE, 6'd63, 6'd63);
    send_cmd(CMD_EDGE, 6'd63, 6'd63);
    send_cmd(CMD_SEARCH, 6'd63, 6'd2);
    send_cmd(CMD_SEARCH, 6'd62, 6'd63);
    send_cmd(CMD_EDGE, 6'd42, 6'd21);
    send_cmd(CMD_SEARCH, 6'd42, 6'd21);
    send_cmd(CMD_SEARCH, 6'd21, 6'd42);
    random_phase(60);

    hold_req = 1'b1;
    random_phase(40);

    write_vertex_count(7'd1);
    send_cmd(CMD_EDGE, 6'd0, 6'd1);
    send_cmd(CMD_SEARCH, 6'd0, 6'd0);
    send_cmd(CMD_SEARCH, 6'd0, 6'd1);
    send_cmd(CMD_SEARCH, 6'd1, 6'd1);
    random_phase(30);

    write_vertex_count(7'd0);
    send_cmd(CMD_EDGE, 6'd0, 6'd0);
    send_cmd(CMD_SEARCH, 6'd0, 6'd0);
    random_phase(20);

    write_vertex_count(7'd127);
    send_cmd(CMD_CLEAR, 6'd63, 6'd63);
    send_cmd(CMD_EDGE, 6'd63, 6'd0);
    send_cmd(CMD_SEARCH, 6'd63, 6'd0);
    random_phase(40);

    write_vertex_count(7'd2);
    random_phase(40);

    write_vertex_count(7'd64);
    random_phase(60);

    for (int p = 0; p < 4; p++) begin
      write_vertex_count(VCOUNT_W'($urandom_range(3, 63)));
      random_phase(50);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    if (sb.errors == 0 && sb.path_q.size() == 0) begin
      $display("dfs_path_finder test passed");
    end else begin
      $display("dfs_path_finder test failed");
    end
    $finish;
  end

endmodule
